>>> src/ffba_pkg.sv
// shared field widths, command codes and status codes for the first-fit allocator
package ffba_pkg;

  // fixed field widths of the ports
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PART_W   = 4;
  localparam int unsigned AMT_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BLK_W    = 5;

  // reset value of the blocks-in-use register
  localparam logic [BLK_W-1:0] BLOCKS_RESET = 5'd16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_BUSY = 2'd2;

endpackage

>>> src/ffba_ram.sv
// generic single-write, single-read ram with registered read data
module ffba_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/ffba_table.sv
// partition table: ram of {busy, granted, size} with per-entry written bits
module ffba_table #(
  parameter int unsigned PARTITIONS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [$clog2(PARTITIONS)-1:0] rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(PARTITIONS)-1:0] wr_addr_i,
  input  logic                          wr_busy_i,
  input  logic [SIZE_BITS-1:0]          wr_granted_i,
  input  logic [SIZE_BITS-1:0]          wr_size_i,
  output logic                          rd_busy_o,
  output logic [SIZE_BITS-1:0]          rd_granted_o,
  output logic [SIZE_BITS-1:0]          rd_size_o
);

  localparam int unsigned EW = 1 + 2 * SIZE_BITS;

  logic [PARTITIONS-1:0] written_q;
  logic                  rd_written_q;
  logic [EW-1:0]         rd_data;
  logic [EW-1:0]         entry;

  ffba_ram #(
    .WIDTH (EW),
    .DEPTH (PARTITIONS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en_i),
    .wr_addr_i (wr_addr_i),
    .wr_data_i ({wr_busy_i, wr_granted_i, wr_size_i}),
    .rd_addr_i (rd_addr_i),
    .rd_data_o (rd_data)
  );

  // written bits, cleared at reset so untouched entries read as free and empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      rd_written_q <= written_q[rd_addr_i];
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // mask read data of entries never written
  assign entry        = rd_written_q ? rd_data : '0;
  assign rd_busy_o    = entry[EW-1];
  assign rd_granted_o = entry[2*SIZE_BITS-1:SIZE_BITS];
  assign rd_size_o    = entry[SIZE_BITS-1:0];

endmodule

>>> src/first_fit_block_allocator.sv
// first-fit partition allocator top level: command sequencer around the partition table
//
// channel  direction  handshake                     payload
// cmd      in         start_i, busy_o               command_i, partition_i, amount_i
// result   out        valid_o (one-cycle strobe)    status_o, granted_partition_o,
//                                                   granted_amount_o
// cfg      in         cfg_valid_i, cfg_ready_o      cfg_data_i (blocks in use)
//
// load, release and the unused command read their table entry; load writes it back, and
// release does so only for a busy partition. allocate reads one table entry per cycle from
// entry 0 to the first fit, at most min(blocks in use, PARTITIONS) entries; the single ram
// read port sets this rate. an out-of-range partition or zero blocks in use
// finishes in the accept cycle. the result strobes in the cycle after the item ends.
// reset clears the table at once through per-entry written bits; the receiver cannot stall.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned PARTITIONS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [PART_W-1:0]   partition_i,
  input  logic [AMT_W-1:0]    amount_i,
  output logic                valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [PART_W-1:0]   granted_partition_o,
  output logic [AMT_W-1:0]    granted_amount_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [BLK_W-1:0]    cfg_data_i
);

  localparam int unsigned IW = $clog2(PARTITIONS);
  localparam int unsigned CW = $clog2(PARTITIONS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_ACCESS = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [BLK_W-1:0]     blocks_q;
  logic [CMD_W-1:0]     cmd_q;
  logic [PART_W-1:0]    part_q;
  logic [SIZE_BITS-1:0] amt_q;
  logic [CW-1:0]        scan_q, scan_d;
  logic [CW-1:0]        limit_q;

  logic                 res_valid_q, res_valid_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic [PART_W-1:0]    res_part_q, res_part_d;
  logic [AMT_W-1:0]     res_amt_q, res_amt_d;

  logic                 accept;
  logic                 in_range;
  logic [CW-1:0]        limit;
  logic [CW-1:0]        scan_nxt;
  logic [SIZE_BITS-1:0] amt_in;

  logic [IW-1:0]        rd_addr;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic                 wr_busy;
  logic [SIZE_BITS-1:0] wr_granted;
  logic [SIZE_BITS-1:0] wr_size;
  logic                 rd_busy;
  logic [SIZE_BITS-1:0] rd_granted;
  logic [SIZE_BITS-1:0] rd_size;
  logic                 fit;

  ffba_table #(
    .PARTITIONS (PARTITIONS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_addr_i    (rd_addr),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_busy_i    (wr_busy),
    .wr_granted_i (wr_granted),
    .wr_size_i    (wr_size),
    .rd_busy_o    (rd_busy),
    .rd_granted_o (rd_granted),
    .rd_size_o    (rd_size)
  );

  // input decode
  assign accept   = start_i && (state_q == S_IDLE);
  assign in_range = 32'(partition_i) < 32'(PARTITIONS);
  assign limit    = (32'(blocks_q) > 32'(PARTITIONS)) ? CW'(PARTITIONS) : CW'(blocks_q);
  assign amt_in   = SIZE_BITS'(amount_i);
  assign scan_nxt = scan_q + CW'(1);
  assign fit      = !rd_busy && (rd_size >= amt_q);

  // table read address: partition (entry 0 for allocate) on accept, next entry while scanning
  always_comb begin
    if (state_q == S_IDLE) begin
      rd_addr = (command_i == CMD_ALLOC) ? '0 : IW'(partition_i);
    end else begin
      rd_addr = IW'(scan_nxt);
    end
  end

  // sequencer, write back and result selection
  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_part_d   = res_part_q;
    res_amt_d    = res_amt_q;
    wr_en        = 1'b0;
    wr_addr      = IW'(part_q);
    wr_busy      = rd_busy;
    wr_granted   = rd_granted;
    wr_size      = rd_size;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          scan_d = '0;
          if (command_i == CMD_ALLOC) begin
            if (limit == '0) begin
              res_valid_d  = 1'b1;
              res_status_d = ST_NO_FIT;
              res_part_d   = partition_i;
              res_amt_d    = '0;
            end else begin
              state_d = S_SCAN;
            end
          end else if (in_range) begin
            state_d = S_ACCESS;
          end else begin
            // partition beyond the table
            res_valid_d  = 1'b1;
            res_status_d = (command_i == CMD_RELEASE) ? ST_NOT_BUSY : ST_DONE;
            res_part_d   = partition_i;
            res_amt_d    = '0;
          end
        end
      end
      S_SCAN: begin
        if (fit) begin
          wr_en        = 1'b1;
          wr_addr      = IW'(scan_q);
          wr_busy      = 1'b1;
          wr_granted   = amt_q;
          state_d      = S_IDLE;
          res_valid_d  = 1'b1;
          res_status_d = ST_DONE;
          res_part_d   = PART_W'(scan_q);
          res_amt_d    = AMT_W'(amt_q);
        end else if (scan_nxt < limit_q) begin
          scan_d = scan_nxt;
        end else begin
          state_d      = S_IDLE;
          res_valid_d  = 1'b1;
          res_status_d = ST_NO_FIT;
          res_part_d   = part_q;
          res_amt_d    = '0;
        end
      end
      S_ACCESS: begin
        state_d     = S_IDLE;
        res_valid_d = 1'b1;
        res_part_d  = part_q;
        case (cmd_q)
          CMD_LOAD: begin
            wr_en        = 1'b1;
            wr_size      = amt_q;
            res_status_d = ST_DONE;
            res_amt_d    = AMT_W'(rd_granted);
          end
          CMD_RELEASE: begin
            if (rd_busy) begin
              wr_en        = 1'b1;
              wr_busy      = 1'b0;
              wr_granted   = '0;
              res_status_d = ST_DONE;
              res_amt_d    = '0;
            end else begin
              res_status_d = ST_NOT_BUSY;
              res_amt_d    = AMT_W'(rd_granted);
            end
          end
          default: begin
            res_status_d = ST_DONE;
            res_amt_d    = AMT_W'(rd_granted);
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      blocks_q    <= BLOCKS_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        blocks_q <= cfg_data_i;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      part_q  <= partition_i;
      amt_q   <= amt_in;
      limit_q <= limit;
    end
    res_status_q <= res_status_d;
    res_part_q   <= res_part_d;
    res_amt_q    <= res_amt_d;
  end

  assign busy_o              = (state_q != S_IDLE);
  assign cfg_ready_o         = 1'b1;
  assign valid_o             = res_valid_q;
  assign status_o            = res_status_q;
  assign granted_partition_o = res_part_q;
  assign granted_amount_o    = res_amt_q;

`ifndef SYNTHESIS
  // a result transfer only follows the end of an item
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (state_q == S_IDLE))
    else $error("result strobe while an item is in progress");

  // the scan never passes the allowed partitions
  a_scan_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_q < limit_q))
    else $error("scan index beyond blocks in use");

  // a table access is always followed by a result and a return to idle in the next cycle
  a_access_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCESS) |=> (valid_o && (state_q == S_IDLE)))
    else $error("table access did not produce a result");

  // the table is written only while an item is in progress
  a_write_in_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((state_q == S_SCAN) || (state_q == S_ACCESS)))
    else $error("table write outside an item");
`endif

endmodule
